FILE: rtl/fixed_block_pool_allocator_core_macros.svh
// Assertion macros for the block pool allocator checker.
// Each macro expects clk and arst_n in scope at the point of use.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FBPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/fbpa_pkg.sv
// Shared types, widths and helper functions for the block pool allocator.
// No dependencies; imported by the divider, the allocator core and the checker.
`default_nettype none

package fbpa_pkg;

	localparam int MAX_BLOCKS  = 1024;
	localparam int IDX_W       = $clog2(MAX_BLOCKS);
	localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
	localparam int LINK_W      = IDX_W + 1;

	localparam int ADDR_W      = 32;
	localparam int CFG_WORDS_W = 15;
	localparam int CFG_COUNT_W = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	// block size in bytes: up to four times the largest word count
	localparam int BYTES_W     = CFG_WORDS_W + 2;
	localparam int REGION_W    = BYTES_W + CNT_W;
	localparam int DIV_CNT_W   = $clog2(REGION_W + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE  = 2'd0,
		CFG_WORDS = 2'd1,
		CFG_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_RANGE     = 2'd2,
		ST_MISALIGN  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POP,
		S_ADDR,
		S_RANGE,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                done;
		logic [REGION_W-1:0] quotient;
		logic [BYTES_W-1:0]  remainder;
	} div_res_t;

	// zero words behave as one word
	function automatic logic [BYTES_W-1:0] block_bytes_f(input logic [CFG_WORDS_W-1:0] w);
		logic [CFG_WORDS_W-1:0] ww;
		ww = (w == '0) ? CFG_WORDS_W'(1) : w;
		return {ww, 2'b00};
	endfunction

	// clamp the configured count to the pool capacity
	function automatic logic [CNT_W-1:0] eff_count_f(input logic [CFG_COUNT_W-1:0] c);
		logic [31:0] cw;
		cw = 32'(c);
		return (cw > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(cw);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/fbpa_link_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the free-list links; no dependencies.
`default_nettype none

module fbpa_link_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 11
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/fbpa_divider.sv
// Restoring divider, one quotient bit per cycle, for the free-path offset.
// Depends on fbpa_pkg for widths and the result struct.
`default_nettype none

module fbpa_divider import fbpa_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [REGION_W-1:0] dividend,
	input  wire logic [BYTES_W-1:0]  divisor,
	output      div_res_t            res
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [BYTES_W-1:0]   rem_q;
	logic [REGION_W-1:0]  quo_q;
	logic [BYTES_W-1:0]   dsr_q;

	logic [BYTES_W:0]     shifted;
	logic [BYTES_W+1:0]   diff;
	logic                 fits;

	always_comb begin
		shifted = {rem_q, quo_q[REGION_W-1]};
		diff    = {1'b0, shifted} - {2'b00, dsr_q};
		fits    = !diff[BYTES_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(REGION_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// shift the next dividend bit in, subtract when it fits
			rem_q <= fits ? diff[BYTES_W-1:0] : shifted[BYTES_W-1:0];
			quo_q <= {quo_q[REGION_W-2:0], fits};
		end
	end

	assign res.done      = done_q;
	assign res.quotient  = quo_q;
	assign res.remainder = rem_q;

endmodule

`default_nettype wire

FILE: rtl/fixed_block_pool_allocator_core.sv
// Fixed-size block pool allocator. The pool spans block_count blocks of
// 4*block_words bytes from base_address; any known register write resets
// the pool. Allocate hands out never-used blocks in address order, then pops
// a LIFO free list whose links live in a 1024-entry synchronous RAM. Free
// checks range and alignment, then pushes the block. One transaction is in
// work at a time; the output register lets the next transaction in while a
// result waits. Allocate runs decode, address and done states, with a RAM
// read state after decode when it pops the free list, or goes from decode to
// done when no block is left. A free outside the region ends after the range
// check; any other free then runs the 28-step bit-serial offset divider.
// Depends on fbpa_pkg, fbpa_divider and fbpa_link_ram.
`default_nettype none

module fixed_block_pool_allocator_core import fbpa_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output      logic                  in_ready,
	input  wire logic                  opcode,
	input  wire logic [ADDR_W-1:0]     address,
	output      logic                  out_valid,
	input  wire logic                  out_ready,
	output      logic [1:0]            status,
	output      logic [ADDR_W-1:0]     block_address
);

	state_t state_q, state_d;

	logic [ADDR_W-1:0]      base_q;
	logic [CFG_WORDS_W-1:0] words_q;
	logic [CFG_COUNT_W-1:0] count_q;

	logic [CNT_W-1:0]       unlinked_left_q;
	logic [IDX_W-1:0]       unlinked_index_q;
	logic [IDX_W-1:0]       list_head_q;
	logic                   list_nonempty_q;

	logic                   op_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [REGION_W-1:0]    prod_q;
	logic [ADDR_W-1:0]      off_q;
	logic                   borrow_q;
	status_t                res_status_q;
	logic [ADDR_W-1:0]      res_addr_q;
	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [ADDR_W-1:0]      block_address_q;

	logic [BYTES_W-1:0]     bytes;
	logic [CNT_W-1:0]       eff_count;
	logic [CNT_W-1:0]       mul_a;
	logic [REGION_W-1:0]    prod;
	logic [ADDR_W:0]        off_full;
	logic                   cfg_known;
	logic [CFG_COUNT_W-1:0] cfg_new_count;
	logic                   accept;
	logic                   out_load;
	logic                   in_range;
	logic                   aligned;

	logic                   ram_we;
	logic                   ram_re;
	logic [LINK_W-1:0]      ram_wdata;
	logic [LINK_W-1:0]      ram_rdata;
	logic [IDX_W-1:0]       free_idx;

	logic                   div_start;
	div_res_t               div_res;

	// ------------------------------------------------------------------
	// Datapath helpers
	// ------------------------------------------------------------------
	always_comb begin
		bytes     = block_bytes_f(words_q);
		eff_count = eff_count_f(count_q);
		// one shared multiplier: block offset on allocate, region size on free
		if (op_q == OP_FREE) begin
			mul_a = eff_count;
		end else if (unlinked_left_q != '0) begin
			mul_a = CNT_W'(unlinked_index_q);
		end else begin
			mul_a = CNT_W'(list_head_q);
		end
		prod     = REGION_W'(mul_a * bytes);
		off_full = {1'b0, addr_q} - {1'b0, base_q};
		in_range = !borrow_q && (off_q < ADDR_W'(prod_q));
		aligned  = (div_res.remainder == '0);
		free_idx = div_res.quotient[IDX_W-1:0];
		ram_wdata = list_nonempty_q ? (LINK_W'(list_head_q) + 1'b1) : '0;
	end

	always_comb begin
		cfg_known     = 1'b1;
		cfg_new_count = count_q;
		case (cfg_index)
			CFG_BASE:  cfg_new_count = count_q;
			CFG_WORDS: cfg_new_count = count_q;
			CFG_COUNT: cfg_new_count = cfg_data[CFG_COUNT_W-1:0];
			default:   cfg_known     = 1'b0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (op_q == OP_FREE) begin
					state_d = S_RANGE;
				end else if (unlinked_left_q != '0) begin
					state_d = S_ADDR;
				end else if (list_nonempty_q) begin
					ram_re  = 1'b1;
					state_d = S_POP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_POP: begin
				state_d = S_ADDR;
			end
			S_ADDR: begin
				state_d = S_DONE;
			end
			S_RANGE: begin
				if (in_range) begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				if (div_res.done) begin
					ram_we  = aligned;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Configuration and pool bookkeeping
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q           <= '0;
			words_q          <= CFG_WORDS_W'(1);
			count_q          <= '0;
			unlinked_left_q  <= '0;
			unlinked_index_q <= '0;
			list_head_q      <= '0;
			list_nonempty_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE:  base_q  <= cfg_data;
				CFG_WORDS: words_q <= cfg_data[CFG_WORDS_W-1:0];
				CFG_COUNT: count_q <= cfg_data[CFG_COUNT_W-1:0];
				default:   ;
			endcase
			// any known register write re-initializes the pool
			if (cfg_known) begin
				unlinked_left_q  <= eff_count_f(cfg_new_count);
				unlinked_index_q <= '0;
				list_head_q      <= '0;
				list_nonempty_q  <= 1'b0;
			end
		end else begin
			case (state_q)
				S_DECODE: begin
					if (op_q == OP_ALLOC && unlinked_left_q != '0) begin
						unlinked_left_q  <= unlinked_left_q - 1'b1;
						unlinked_index_q <= unlinked_index_q + 1'b1;
					end
				end
				S_POP: begin
					// link of zero ends the list, else it holds index plus one
					if (ram_rdata == '0) begin
						list_nonempty_q <= 1'b0;
						list_head_q     <= '0;
					end else begin
						list_head_q <= IDX_W'(ram_rdata - 1'b1);
					end
				end
				S_DIV: begin
					if (ram_we) begin
						list_head_q     <= free_idx;
						list_nonempty_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Transaction payload
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			addr_q <= address;
		end
		case (state_q)
			S_DECODE: begin
				prod_q       <= prod;
				off_q        <= off_full[ADDR_W-1:0];
				borrow_q     <= off_full[ADDR_W];
				res_addr_q   <= '0;
				res_status_q <= (op_q == OP_ALLOC && unlinked_left_q == '0 &&
					!list_nonempty_q) ? ST_EMPTY : ST_OK;
			end
			S_ADDR: begin
				res_addr_q <= base_q + ADDR_W'(prod_q);
			end
			S_RANGE: begin
				if (!in_range) begin
					res_status_q <= ST_RANGE;
				end
			end
			S_DIV: begin
				if (div_res.done && !aligned) begin
					res_status_q <= ST_MISALIGN;
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q        <= res_status_q;
			block_address_q <= res_addr_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign block_address = block_address_q;

	// ------------------------------------------------------------------
	// Units
	// ------------------------------------------------------------------
	fbpa_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (off_q[REGION_W-1:0]),
		.divisor  (bytes),
		.res      (div_res)
	);

	fbpa_link_ram #(
		.DEPTH (MAX_BLOCKS),
		.WIDTH (LINK_W)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (list_head_q),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

FILE: rtl/fbpa_checker.sv
// Port-level checks for the block pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_core_macros.svh.
`default_nettype none

`include "fixed_block_pool_allocator_core_macros.svh"

module fbpa_checker import fbpa_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  cfg_we,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic                  opcode,
	input wire logic [ADDR_W-1:0]     address,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [1:0]            status,
	input wire logic [ADDR_W-1:0]     block_address
);

	// a failed transaction never carries an address
	`FBPA_ASSERT_NOW(a_fail_zero_addr, out_valid && (status != ST_OK), block_address == '0, "failed result with nonzero address")

	// one transaction in work at a time
	`FBPA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "input accepted while busy")

	// a waiting result holds
	`FBPA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(block_address), "result changed while stalled")

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_checker (.*);

`default_nettype wire
